// ===== rtl/swbl_pkg.sv =====
// Shared types and constants for the single-wire backlight encoder.
// No dependencies; used by every module of the block.
package swbl_pkg;

   localparam int LEVEL_W  = 8;
   localparam int DUR_W    = 12;
   localparam int IDX_W    = 5;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Register map (byte addresses, word index in paddr[2])
   localparam logic REG_PANEL_ENABLED = 1'b0;

   // Segment durations in microseconds
   localparam logic [DUR_W-1:0] PRE_LOW_US    = 12'd3000;
   localparam logic [DUR_W-1:0] EW_DELAY_US   = 12'd150;
   localparam logic [DUR_W-1:0] EW_DETECT_US  = 12'd270;
   localparam logic [DUR_W-1:0] EW_WINDOW_US  = 12'd1000 - (EW_DELAY_US + EW_DETECT_US);
   localparam logic [DUR_W-1:0] START_HIGH_US = 12'd5;
   localparam logic [DUR_W-1:0] SHORT_US      = 12'd5;
   localparam logic [DUR_W-1:0] LONG_US       = 12'd20;
   localparam logic [DUR_W-1:0] END_LOW_US    = 12'd10;
   localparam logic [DUR_W-1:0] END_HIGH_US   = 12'd350;
   localparam logic [DUR_W-1:0] ZERO_LOW_US   = 12'd10;

   // Positions inside a run, counted after the preamble
   localparam logic [IDX_W-1:0] PRE_LEN      = 5'd4;
   localparam logic [IDX_W-1:0] POS_START    = 5'd0;
   localparam logic [IDX_W-1:0] POS_LAST_BIT = 5'd16;
   localparam logic [IDX_W-1:0] POS_END_LOW  = 5'd17;
   localparam logic [IDX_W-1:0] RUN_MAX_IDX  = 5'd22;

   typedef enum logic {
      JOB_ZERO,
      JOB_RUN
   } job_kind_type;

   typedef struct packed {
      job_kind_type            kind;
      logic                    pre;
      logic [LEVEL_W-1:0]      level;
      logic [IDX_W-1:0]        idx;
   } job_type;

   typedef struct packed {
      logic                    line_level;
      logic [DUR_W-1:0]        duration_us;
      logic                    last;
   } seg_type;

endpackage

// ===== rtl/single_wire_backlight_encoder_unit.sv =====
// Top level of the single-wire backlight encoder.
// Depends on swbl_pkg, swbl_csr and swbl_seg_gen.
//
// Each brightness request becomes a run of wire segments (level plus duration in
// microseconds), one segment per clock unless stalled: 1 for a zero request, 19
// for a level change, 23 when the entry preamble is sent from a stored level of
// zero, and none for a repeat or while the panel is disabled. The run length is
// set by the job register, which walks one segment index per cycle, unless
// stalled, into a one-deep result register. A new request is taken in the cycle
// the previous run hands over its last segment, so runs follow each other with
// no gap; segment-less requests load no job. No clearing pass follows reset.
module single_wire_backlight_encoder_unit
   import swbl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [LEVEL_W-1:0] req_brightness,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_line_level,
   output logic [DUR_W-1:0]   rsp_duration_us,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   logic               panel_enabled;
   logic               req_accept;
   logic               out_adv;
   logic               seg_fire;
   logic               dec_job;
   job_type            dec;
   seg_type            seg;

   logic               job_valid_ff;
   logic               job_valid_in;
   job_type            job_ff;
   job_type            job_in;
   logic [LEVEL_W-1:0] prev_level_ff;
   logic [LEVEL_W-1:0] prev_level_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   seg_type            rsp_ff;
   seg_type            rsp_in;

   swbl_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .panel_enabled (panel_enabled)
   );

   swbl_seg_gen u_seg_gen (
      .job (job_ff),
      .seg (seg)
   );

   assign out_adv    = !rsp_valid_ff || !rsp_stall;
   assign seg_fire   = job_valid_ff && out_adv;
   assign req_stall  = job_valid_ff && !(seg_fire && seg.last);
   assign req_accept = req_valid && !req_stall;

   // Decode the request against the stored level
   always_comb begin
      dec_job       = 1'b0;
      dec.kind      = JOB_RUN;
      dec.pre       = (prev_level_ff == '0);
      dec.level     = req_brightness;
      dec.idx       = '0;
      prev_level_in = prev_level_ff;
      if (req_accept && panel_enabled) begin
         if (req_brightness == '0) begin
            dec_job       = 1'b1;
            dec.kind      = JOB_ZERO;
            dec.pre       = 1'b0;
            prev_level_in = '0;
         end else if (req_brightness != prev_level_ff) begin
            dec_job       = 1'b1;
            prev_level_in = req_brightness;
         end
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      if (dec_job) begin
         job_valid_in = 1'b1;
         job_in       = dec;
      end else if (seg_fire && seg.last) begin
         job_valid_in = 1'b0;
      end else if (seg_fire) begin
         job_in.idx = job_ff.idx + 5'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_adv) begin
         rsp_valid_in = job_valid_ff;
         rsp_in       = seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff  <= 1'b0;
         prev_level_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         job_valid_ff  <= job_valid_in;
         prev_level_ff <= prev_level_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_level  = rsp_ff.line_level;
   assign rsp_duration_us = rsp_ff.duration_us;
   assign rsp_last        = rsp_ff.last;

`ifndef SYNTHESIS

   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_ff.idx <= RUN_MAX_IDX))
      else $error("segment index past end of run");

   a_zero_single : assert property (@(posedge clock) disable iff (reset)
      (seg_fire && (job_ff.kind == JOB_ZERO)) |=> (rsp_valid && rsp_last && !rsp_line_level))
      else $error("zero request did not give a single low segment");

   a_preamble_load : assert property (@(posedge clock) disable iff (reset)
      (dec_job && (dec.kind == JOB_RUN) && (prev_level_ff == '0))
      |=> (job_valid_ff && job_ff.pre && (job_ff.idx == '0)))
      else $error("preamble not loaded from stored level zero");

   a_disabled_hold : assert property (@(posedge clock) disable iff (reset)
      (req_accept && !panel_enabled) |=> $stable(prev_level_ff))
      else $error("stored level changed while panel disabled");

`endif

endmodule

// ===== rtl/swbl_csr.sv =====
// APB-style configuration register block: holds panel_enabled.
// Depends on swbl_pkg.
module swbl_csr
   import swbl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output logic              panel_enabled
);

   logic panel_enabled_ff;
   logic panel_enabled_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PANEL_ENABLED);

   always_comb begin
      panel_enabled_in = panel_enabled_ff;
      if (wr_en) begin
         panel_enabled_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_enabled_ff <= 1'b1;
      end else begin
         panel_enabled_ff <= panel_enabled_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_PANEL_ENABLED) begin
         prdata = {{(CSR_DW-1){1'b0}}, panel_enabled_ff};
      end
   end

   assign panel_enabled = panel_enabled_ff;

endmodule

// ===== rtl/swbl_seg_gen.sv =====
// Segment lookup: maps the current job and its segment index to one line segment.
// Depends on swbl_pkg.
module swbl_seg_gen
   import swbl_pkg::*;
(
   input  job_type job,
   output seg_type seg
);

   logic [IDX_W-1:0] pos;
   logic [IDX_W-1:0] bit_pos;
   logic [2:0]       bit_sel;
   logic             data_bit;

   always_comb begin
      pos      = job.pre ? (job.idx - PRE_LEN) : job.idx;
      bit_pos  = pos - 5'd1;
      // MSB first: pairs of segments walk bits 7 down to 0
      bit_sel  = 3'd7 - bit_pos[3:1];
      data_bit = job.level[bit_sel];

      seg.line_level  = 1'b1;
      seg.duration_us = END_HIGH_US;
      seg.last        = 1'b0;

      if (job.kind == JOB_ZERO) begin
         seg.line_level  = 1'b0;
         seg.duration_us = ZERO_LOW_US;
         seg.last        = 1'b1;
      end else if (job.pre && (job.idx < PRE_LEN)) begin
         case (job.idx[1:0])
            2'd0: begin
               seg.line_level  = 1'b0;
               seg.duration_us = PRE_LOW_US;
            end
            2'd1: begin
               seg.line_level  = 1'b1;
               seg.duration_us = EW_DELAY_US;
            end
            2'd2: begin
               seg.line_level  = 1'b0;
               seg.duration_us = EW_DETECT_US;
            end
            default: begin
               seg.line_level  = 1'b1;
               seg.duration_us = EW_WINDOW_US;
            end
         endcase
      end else if (pos == POS_START) begin
         seg.line_level  = 1'b1;
         seg.duration_us = START_HIGH_US;
      end else if (pos <= POS_LAST_BIT) begin
         // low half first, then high half; a one has the long high
         seg.line_level = bit_pos[0];
         if (bit_pos[0] == data_bit) begin
            seg.duration_us = LONG_US;
         end else begin
            seg.duration_us = SHORT_US;
         end
      end else if (pos == POS_END_LOW) begin
         seg.line_level  = 1'b0;
         seg.duration_us = END_LOW_US;
      end else begin
         seg.line_level  = 1'b1;
         seg.duration_us = END_HIGH_US;
         seg.last        = 1'b1;
      end
   end

endmodule
